// File: hw/rtl/uart_frame_command_responder_assert.svh
// ----------------------------------------------------------------------------
// uart_frame_command_responder_assert
// Assertion macros for the responder's RTL, included by ufcr_emit.
// ----------------------------------------------------------------------------
`ifndef UART_FRAME_COMMAND_RESPONDER_ASSERT_SVH
`define UART_FRAME_COMMAND_RESPONDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UFCR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UFCR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ufcr_pkg.sv
// ----------------------------------------------------------------------------
// ufcr_pkg
// Types and constants of the frame command responder: frame layout, command
// codes, status and LED codes, and the structs passed between its modules.
// ----------------------------------------------------------------------------
package ufcr_pkg;

	localparam int FRAME_LEN = 21;
	localparam int CNT_W     = 5;

	localparam logic [CNT_W-1:0] IDX_HEAD  = 5'd0;
	localparam logic [CNT_W-1:0] IDX_CMD   = 5'd1;
	localparam logic [CNT_W-1:0] IDX_SUB   = 5'd2;
	localparam logic [CNT_W-1:0] IDX_DATA0 = 5'd3;
	localparam logic [CNT_W-1:0] IDX_DATA1 = 5'd4;
	localparam logic [CNT_W-1:0] IDX_DATA2 = 5'd5;
	localparam logic [CNT_W-1:0] IDX_DATA3 = 5'd6;
	localparam logic [CNT_W-1:0] IDX_CHK   = 5'd19;
	localparam logic [CNT_W-1:0] IDX_TAIL  = 5'd20;
	localparam logic [CNT_W-1:0] FRAME_CNT = 5'd21;

	localparam logic [7:0] HEAD_BYTE       = 8'hAF;
	localparam logic [7:0] TAIL_BYTE       = 8'hFF;
	localparam logic [7:0] CMD_OPEN        = 8'h01;
	localparam logic [7:0] CMD_HEART       = 8'h00;
	localparam logic [7:0] SUB_REQ         = 8'h00;
	localparam logic [7:0] SUB_OPEN_REPLY  = 8'h00;
	localparam logic [7:0] SUB_HEART_REPLY = 8'h01;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_IDLE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FRAME = 2'd1,
		STATUS_SUM   = 2'd2,
		STATUS_CMD   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		LED_NONE = 2'd0,
		LED_RED  = 2'd1,
		LED_BLUE = 2'd2
	} led_t;

	typedef struct packed {
		status_t status;
		logic    is_open;
	} verdict_t;

	typedef struct packed {
		status_t    status;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
		logic       unlock;
		led_t       led;
	} result_t;

endpackage

// File: hw/rtl/ufcr_store.sv
// ----------------------------------------------------------------------------
// ufcr_store
// Holds the bytes of the current burst that the check needs, the byte count
// and a running sum of the body, and gives the verdict on the stored frame.
// ----------------------------------------------------------------------------
module ufcr_store (
	input  logic                verdict_clk_unused_guard_n, // tied high, see top
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [7:0]          rx_byte,
	input  logic                clr,
	output ufcr_pkg::verdict_t  verdict
);

	logic [ufcr_pkg::CNT_W-1:0] count_q;
	logic [7:0]                 head_q;
	logic [7:0]                 cmd_q;
	logic [7:0]                 sub_q;
	logic [7:0]                 chk_q;
	logic [7:0]                 tail_q;
	logic [7:0]                 sum_q;

	// Bytes beyond the 21st are dropped; the count stays at 21.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
			cmd_q   <= '0;
			sub_q   <= '0;
			chk_q   <= '0;
			tail_q  <= '0;
			sum_q   <= '0;
		end else if (clr) begin
			count_q <= '0;
			head_q  <= '0;
			cmd_q   <= '0;
			sub_q   <= '0;
			chk_q   <= '0;
			tail_q  <= '0;
			sum_q   <= '0;
		end else if (wr_en && verdict_clk_unused_guard_n
				&& (count_q < ufcr_pkg::FRAME_CNT)) begin
			count_q <= count_q + 5'd1;
			if (count_q == ufcr_pkg::IDX_HEAD) head_q <= rx_byte;
			if (count_q == ufcr_pkg::IDX_CMD)  cmd_q  <= rx_byte;
			if (count_q == ufcr_pkg::IDX_SUB)  sub_q  <= rx_byte;
			if (count_q == ufcr_pkg::IDX_CHK)  chk_q  <= rx_byte;
			if (count_q == ufcr_pkg::IDX_TAIL) tail_q <= rx_byte;
			if ((count_q >= ufcr_pkg::IDX_CMD) && (count_q < ufcr_pkg::IDX_CHK)) begin
				sum_q <= sum_q + rx_byte;
			end
		end
	end

	always_comb begin
		verdict.is_open = 1'b0;
		priority if ((head_q != ufcr_pkg::HEAD_BYTE) || (tail_q != ufcr_pkg::TAIL_BYTE)) begin
			verdict.status = ufcr_pkg::STATUS_FRAME;
		end else if (sum_q != chk_q) begin
			verdict.status = ufcr_pkg::STATUS_SUM;
		end else if ((cmd_q == ufcr_pkg::CMD_OPEN) && (sub_q == ufcr_pkg::SUB_REQ)) begin
			verdict.status  = ufcr_pkg::STATUS_OK;
			verdict.is_open = 1'b1;
		end else if ((cmd_q == ufcr_pkg::CMD_HEART) && (sub_q == ufcr_pkg::SUB_REQ)) begin
			verdict.status = ufcr_pkg::STATUS_OK;
		end else begin
			verdict.status = ufcr_pkg::STATUS_CMD;
		end
	end

endmodule

// File: hw/rtl/ufcr_emit.sv
// ----------------------------------------------------------------------------
// ufcr_emit
// Reply sequencer: takes a verdict with the time and battery level, and sends
// either a single status item or the 21 bytes of the reply frame.
// ----------------------------------------------------------------------------
module ufcr_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  ufcr_pkg::verdict_t verdict,
	input  logic [31:0]        time_ms,
	input  logic [7:0]         batt_level,
	input  logic               out_ready,
	output logic               out_valid,
	output ufcr_pkg::result_t  result,
	output logic               free
);

	`include "uart_frame_command_responder_assert.svh"

	logic                       busy_q;
	logic [ufcr_pkg::CNT_W-1:0] idx_q;
	ufcr_pkg::status_t          status_q;
	logic                       open_q;
	logic [31:0]                time_q;
	logic [7:0]                 batt_q;
	logic [7:0]                 rsum_q;
	logic [7:0]                 rsum_d;
	logic                       ok;
	logic                       done;

	// Sum of reply bytes 1..18; only the command, subcommand and data bytes
	// can be non-zero.
	always_comb begin
		if (verdict.is_open) begin
			rsum_d = ufcr_pkg::CMD_OPEN + ufcr_pkg::SUB_OPEN_REPLY + time_ms[7:0]
				+ time_ms[15:8] + time_ms[23:16] + time_ms[31:24];
		end else begin
			rsum_d = ufcr_pkg::CMD_HEART + ufcr_pkg::SUB_HEART_REPLY + batt_level;
		end
	end

	assign ok   = (status_q == ufcr_pkg::STATUS_OK);
	assign done = busy_q && out_ready && result.last;
	assign free = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= verdict.status;
			open_q   <= verdict.is_open;
			time_q   <= time_ms;
			batt_q   <= batt_level;
			rsum_q   <= rsum_d;
		end
	end

	always_comb begin
		result.status   = status_q;
		result.tx_valid = ok;
		result.last     = !ok || (idx_q == ufcr_pkg::IDX_TAIL);
		result.unlock   = ok && (idx_q == ufcr_pkg::IDX_HEAD) && open_q;
		result.led      = ufcr_pkg::LED_NONE;
		if (ok && (idx_q == ufcr_pkg::IDX_HEAD)) begin
			result.led = open_q ? ufcr_pkg::LED_BLUE : ufcr_pkg::LED_RED;
		end
		unique case (idx_q)
			ufcr_pkg::IDX_HEAD:  result.tx_byte = ufcr_pkg::HEAD_BYTE;
			ufcr_pkg::IDX_CMD:   result.tx_byte = open_q ? ufcr_pkg::CMD_OPEN
				: ufcr_pkg::CMD_HEART;
			ufcr_pkg::IDX_SUB:   result.tx_byte = open_q ? ufcr_pkg::SUB_OPEN_REPLY
				: ufcr_pkg::SUB_HEART_REPLY;
			ufcr_pkg::IDX_DATA0: result.tx_byte = open_q ? time_q[7:0] : batt_q;
			ufcr_pkg::IDX_DATA1: result.tx_byte = open_q ? time_q[15:8] : 8'h00;
			ufcr_pkg::IDX_DATA2: result.tx_byte = open_q ? time_q[23:16] : 8'h00;
			ufcr_pkg::IDX_DATA3: result.tx_byte = open_q ? time_q[31:24] : 8'h00;
			ufcr_pkg::IDX_CHK:   result.tx_byte = rsum_q;
			ufcr_pkg::IDX_TAIL:  result.tx_byte = ufcr_pkg::TAIL_BYTE;
			default:             result.tx_byte = 8'h00;
		endcase
		if (!ok) begin
			result.tx_byte = 8'h00;
		end
	end

	assign out_valid = busy_q;

	`UFCR_ASSERT_IMP(a_idx_range, clk, arst_n, busy_q, idx_q <= ufcr_pkg::IDX_TAIL,
		"reply index ran past the tail byte")
	`UFCR_ASSERT_IMP(a_load_free, clk, arst_n, load, free,
		"reply loaded while an earlier one was still going out")
	`UFCR_ASSERT_IMP(a_error_single, clk, arst_n, busy_q && !ok, result.last && idx_q == '0,
		"error status item is not a single last item")
	`UFCR_ASSERT_NEXT(a_stall_hold, clk, arst_n, busy_q && !out_ready && !load,
		busy_q && $stable(idx_q), "reply position moved during a stall")

endmodule

// File: hw/rtl/uart_frame_command_responder.sv
// ----------------------------------------------------------------------------
// uart_frame_command_responder
// Collects received bytes into a frame, checks it on a line-idle item and
// answers open-door and heartbeat commands with a 21-byte reply frame.
//
// Channel  Dir  tdata                                      tuser     tlast
// s_       in   rx_byte[7:0] time_ms[39:8] battery[47:40]  action    -
// m_       out  status[1:0] tx_byte[9:2] unlock[10]        tx_valid  last
//              led_request[12:11], zero [15:13]
//
// A received-byte item passes the input register and yields no result.
// An idle item is judged in the input register and, in the cycle after, its single
// status item or its 21 reply items follow at one per cycle while m_tready is high. It waits there while
// an earlier reply is still going out, and items behind it wait too.
// Reset clears the byte count, the stored frame bytes and the sequencer.
// A stall on the output holds the current result in place.
// ----------------------------------------------------------------------------
module uart_frame_command_responder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // rx_byte, time_ms, batt_level
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // status, tx_byte, unlock_pulse, led_request, zero
	output logic        m_tuser,  // tx_valid
	output logic        m_tlast   // last
);

	logic               valid_s1;
	logic               action_s1;
	logic [7:0]         rx_byte_s1;
	logic [31:0]        time_s1;
	logic [7:0]         batt_s1;
	logic               advance;
	logic               load;
	logic               emit_free;
	ufcr_pkg::verdict_t verdict;
	ufcr_pkg::result_t  result;

	assign load     = valid_s1 && (action_s1 == ufcr_pkg::ACT_IDLE) && emit_free;
	assign advance  = load || (valid_s1 && (action_s1 == ufcr_pkg::ACT_BYTE));
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1  <= s_tuser;
			rx_byte_s1 <= s_tdata[7:0];
			time_s1    <= s_tdata[39:8];
			batt_s1    <= s_tdata[47:40];
		end
	end

	ufcr_store u_store (
		.verdict_clk_unused_guard_n (1'b1),
		.clk                        (clk),
		.arst_n                     (arst_n),
		.wr_en                      (valid_s1 && (action_s1 == ufcr_pkg::ACT_BYTE)),
		.rx_byte                    (rx_byte_s1),
		.clr                        (load),
		.verdict                    (verdict)
	);

	ufcr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.verdict    (verdict),
		.time_ms    (time_s1),
		.batt_level (batt_s1),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.result     (result),
		.free       (emit_free)
	);

	assign m_tdata = {3'b000, result.led, result.unlock, result.tx_byte, result.status};
	assign m_tuser = result.tx_valid;
	assign m_tlast = result.last;

endmodule
